### src/ratn_pkg.sv
// ----------------------------------------------------------------------------
// ratn_pkg: shared types for the rational normalizer
// Job descriptor passed from the front end to the back end through the queue.
// ----------------------------------------------------------------------------
package ratn_pkg;

	typedef enum logic [1:0] {
		KIND_REDUCE = 2'd0,
		KIND_ZERO   = 2'd1,
		KIND_ERROR  = 2'd2
	} job_kind_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_GCD   = 5'b00010,
		ST_DIVN  = 5'b00100,
		ST_DIVD  = 5'b01000,
		ST_OUT   = 5'b10000
	} back_state_t;

endpackage

### src/ratn_front.sv
// ----------------------------------------------------------------------------
// ratn_front: input classification and job queue
// Classify each input beat, take magnitudes and sign, and hold jobs in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module ratn_front import ratn_pkg::*; #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [WIDTH-1:0] num_in,
	input  logic [WIDTH-1:0] den_in,
	output logic             job_valid,
	input  logic             job_take,
	output job_kind_t        job_kind,
	output logic             job_neg,
	output logic [WIDTH-1:0] job_mn,
	output logic [WIDTH-1:0] job_md
);
	localparam int QW = 2 + 1 + 2 * WIDTH;

	logic [QW-1:0] mem_q [2];
	logic          wr_q, rd_q;
	logic [1:0]    cnt_q;
	logic [QW-1:0] wdata;
	logic [QW-1:0] rdata;
	job_kind_t     kind;
	logic [WIDTH-1:0] mn, md;
	logic          push;

	always_comb begin
		mn = num_in[WIDTH-1] ? (~num_in + 1'b1) : num_in;
		md = den_in[WIDTH-1] ? (~den_in + 1'b1) : den_in;
		if (num_in == '0) kind = KIND_ZERO;
		else if (den_in == '0) kind = KIND_ERROR;
		else kind = KIND_REDUCE;
		wdata = {kind, num_in[WIDTH-1] ^ den_in[WIDTH-1], mn, md};
	end

	assign in_stall = (cnt_q == 2'd2);
	assign push = in_valid && !in_stall;
	assign job_valid = (cnt_q != 2'd0);
	assign rdata = mem_q[rd_q];
	assign job_kind = job_kind_t'(rdata[QW-1 -: 2]);
	assign job_neg  = rdata[2*WIDTH];
	assign job_mn   = rdata[2*WIDTH-1:WIDTH];
	assign job_md   = rdata[WIDTH-1:0];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (job_take) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, job_take};
		end
	end
endmodule

### src/ratn_back.sv
// ----------------------------------------------------------------------------
// ratn_back: GCD and division engine
// Binary GCD one step a cycle, then two restoring divisions one bit a cycle.
// ----------------------------------------------------------------------------
module ratn_back import ratn_pkg::*; #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             job_valid,
	output logic             job_take,
	input  job_kind_t        job_kind,
	input  logic             job_neg,
	input  logic [WIDTH-1:0] job_mn,
	input  logic [WIDTH-1:0] job_md,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [WIDTH-1:0] num_out,
	output logic [WIDTH-1:0] den_out,
	output logic             div_error
);
	localparam int SW = $clog2(WIDTH + 1);
	localparam int CW = $clog2(WIDTH);

	back_state_t      state_q;
	logic [WIDTH-1:0] a_q, b_q, mn_q, md_q, g_q;
	logic [SW-1:0]    sh_q;
	logic [CW-1:0]    bit_q;
	logic [WIDTH-1:0] quo_q, rem_q, dend_q;
	logic             neg_q;
	logic [WIDTH:0]   trial;
	logic [WIDTH-1:0] rem_sh, diff;
	logic [WIDTH-1:0] big, small_v;

	assign job_take = job_valid && (state_q == ST_IDLE);

	always_comb begin
		rem_sh = {rem_q[WIDTH-2:0], dend_q[bit_q]};
		trial  = {1'b0, rem_sh} - {1'b0, g_q};
		big    = (a_q > b_q) ? a_q : b_q;
		small_v = (a_q > b_q) ? b_q : a_q;
		diff   = big - small_v;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						a_q   <= job_mn;
						b_q   <= job_md;
						mn_q  <= job_mn;
						md_q  <= job_md;
						neg_q <= job_neg;
						sh_q  <= '0;
						if (job_kind == KIND_REDUCE) begin
							state_q <= ST_GCD;
						end else begin
							num_out   <= '0;
							den_out   <= (job_kind == KIND_ZERO) ? WIDTH'(1) : '0;
							div_error <= (job_kind == KIND_ERROR);
							out_valid <= 1'b1;
							state_q   <= ST_OUT;
						end
					end
				end
				ST_GCD: begin
					if (a_q == b_q) begin
						g_q    <= a_q << sh_q;
						dend_q <= mn_q;
						rem_q  <= '0;
						quo_q  <= '0;
						bit_q  <= CW'(WIDTH - 1);
						state_q <= ST_DIVN;
					end else if (!a_q[0] && !b_q[0]) begin
						a_q  <= a_q >> 1;
						b_q  <= b_q >> 1;
						sh_q <= sh_q + 1'b1;
					end else if (!a_q[0]) begin
						a_q <= a_q >> 1;
					end else if (!b_q[0]) begin
						b_q <= b_q >> 1;
					end else begin
						a_q <= small_v;
						b_q <= diff >> 1;
					end
				end
				ST_DIVN, ST_DIVD: begin
					if (!trial[WIDTH] || rem_q[WIDTH-1]) begin
						rem_q <= trial[WIDTH-1:0];
						quo_q <= {quo_q[WIDTH-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						quo_q <= {quo_q[WIDTH-2:0], 1'b0};
					end
					if (bit_q == '0) begin
						if (state_q == ST_DIVN) begin
							// numerator quotient ends here: its last bit goes with quo_q into mn_q
							dend_q  <= md_q;
							bit_q   <= CW'(WIDTH - 1);
							state_q <= ST_DIVD;
						end else begin
							state_q <= ST_OUT;
							out_valid <= 1'b1;
							div_error <= 1'b0;
						end
					end else begin
						bit_q <= bit_q - 1'b1;
					end
					if (state_q == ST_DIVN && bit_q == '0) begin
						rem_q <= '0;
						mn_q  <= {quo_q[WIDTH-2:0],
							(!trial[WIDTH] || rem_q[WIDTH-1])};
					end
					if (state_q == ST_DIVD && bit_q == '0) begin
						den_out <= {quo_q[WIDTH-2:0],
							(!trial[WIDTH] || rem_q[WIDTH-1])};
						if (neg_q) num_out <= ~mn_q + 1'b1;
						else if (mn_q[WIDTH-1]) num_out <= {1'b0, {(WIDTH-1){1'b1}}};
						else num_out <= mn_q;
					end
				end
				ST_OUT: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

### src/rational_normalizer_unit.sv
// ----------------------------------------------------------------------------
// rational_normalizer_unit: fraction reduction to lowest terms
// Input channel: in_valid/in_stall carry num_in and den_in (signed).
// Output channel: out_valid/out_stall carry num_out (signed), den_out
// (positive magnitude) and div_error.
// Each beat is classified in the front end and queued (two entries), so
// input beats are taken while the back end works or the output waits.
// The back end runs a binary GCD (one step a cycle) and then two
// restoring divisions of WIDTH quotient bits each; zero cases skip both.
// The single shared GCD/divide engine works on one beat at a time and
// takes the next job from the queue only when idle.
// A zero numerator gives 0/1; zero denominator with a nonzero numerator
// gives 0/0 with div_error high. A positive result of 2^(WIDTH-1)
// saturates to the largest positive value.
// Reset clears the queue and the engine; no beat is pending afterwards.
// When the receiver stalls, hold the result; the queue keeps filling
// until full, then in_stall rises.
// ----------------------------------------------------------------------------
module rational_normalizer_unit import ratn_pkg::*; #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [WIDTH-1:0] num_in,
	input  logic [WIDTH-1:0] den_in,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [WIDTH-1:0] num_out,
	output logic [WIDTH-1:0] den_out,
	output logic             div_error
);
	logic             job_valid, job_take, job_neg;
	job_kind_t        job_kind;
	logic [WIDTH-1:0] job_mn, job_md;

	ratn_front #(.WIDTH(WIDTH)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .num_in, .den_in,
		.job_valid, .job_take, .job_kind, .job_neg, .job_mn, .job_md
	);

	ratn_back #(.WIDTH(WIDTH)) u_back (
		.clk, .arst_n, .job_valid, .job_take, .job_kind, .job_neg,
		.job_mn, .job_md, .out_valid, .out_stall, .num_out, .den_out,
		.div_error
	);
endmodule

### src/ratn_checker.sv
// ----------------------------------------------------------------------------
// ratn_checker: port-level checks for the rational normalizer
// Watch the output channel and result consistency.
// ----------------------------------------------------------------------------
module ratn_checker #(
	parameter int WIDTH = 32
) (
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_stall,
	input logic [WIDTH-1:0] num_out,
	input logic [WIDTH-1:0] den_out,
	input logic             div_error
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(num_out))
		else $error("stalled result changed");
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && div_error |-> den_out == '0 && num_out == '0)
		else $error("error result not zero");
	a_den: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !div_error |-> den_out != '0)
		else $error("zero denominator without error");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && num_out == '0 && !div_error |-> den_out == WIDTH'(1))
		else $error("zero not reduced to 0/1");
endmodule

bind rational_normalizer_unit ratn_checker #(.WIDTH(WIDTH)) u_ratn_checker (
	.clk, .arst_n, .out_valid, .out_stall, .num_out, .den_out, .div_error
);

### verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for rational_normalizer_unit
// Sends signed fractions and checks each reduced result, in order, against a
// behavioral reduction computed on the bench side. Covers the field extremes,
// the zero and saturation cases, random fractions with shared factors, and
// input/output back-pressure.
// ----------------------------------------------------------------------------
module tb;

	localparam int WIDTH = 32;
	localparam int IDLE_LIMIT = 20000;
	localparam logic [WIDTH-1:0] MOST_NEG = {1'b1, {(WIDTH-1){1'b0}}};
	localparam logic [WIDTH-1:0] MOST_POS = {1'b0, {(WIDTH-1){1'b1}}};

	typedef struct packed {
		logic [WIDTH-1:0] num;
		logic [WIDTH-1:0] den;
		logic             err;
	} fraction_t;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic [WIDTH-1:0] num_in;
	logic [WIDTH-1:0] den_in;
	logic             out_valid;
	logic             out_stall;
	logic [WIDTH-1:0] num_out;
	logic [WIDTH-1:0] den_out;
	logic             div_error;

	fraction_t reduced_q[$];
	int        mismatches;
	int        idle_cycles;
	bit        hold_off_req;
	int        burst_left;

	rational_normalizer_unit #(.WIDTH(WIDTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .num_in(num_in), .den_in(den_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.num_out(num_out), .den_out(den_out), .div_error(div_error)
	);

	always begin
		clk = 1'b1; #2;
		clk = 1'b0; #2;
	end

	function automatic logic [WIDTH-1:0] gcd_mag(logic [WIDTH-1:0] a, logic [WIDTH-1:0] b);
		logic [WIDTH-1:0] t;
		while (b != 0) begin
			t = a % b;
			a = b;
			b = t;
		end
		return a;
	endfunction

	// Lowest-terms form of n/d, sign on the numerator.
	function automatic fraction_t reduce_fraction(logic [WIDTH-1:0] n, logic [WIDTH-1:0] d);
		fraction_t r;
		logic [WIDTH-1:0] mn, md, g, rn, rd;
		logic neg;
		r = '0;
		if (n == 0) begin
			r.den = 1;
			return r;
		end
		if (d == 0) begin
			r.err = 1'b1;
			return r;
		end
		neg = n[WIDTH-1] ^ d[WIDTH-1];
		mn = n[WIDTH-1] ? -n : n;
		md = d[WIDTH-1] ? -d : d;
		g = gcd_mag(mn, md);
		rn = mn / g;
		rd = md / g;
		if (neg)
			r.num = -rn;
		else if (rn[WIDTH-1])
			r.num = MOST_POS;	// positive 2^(WIDTH-1) saturates
		else
			r.num = rn;
		r.den = rd;
		return r;
	endfunction

	// Offer one beat; the sender advances only on acceptance.
	task automatic send_fraction(logic [WIDTH-1:0] n, logic [WIDTH-1:0] d);
		in_valid <= 1'b1;
		num_in   <= n;
		den_in   <= d;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		reduced_q.push_back(reduce_fraction(n, d));
	endtask

	// Send with bursty pacing: drop valid for a random gap between bursts.
	task automatic send_paced(logic [WIDTH-1:0] n, logic [WIDTH-1:0] d);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		send_fraction(n, d);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (reduced_q.size() != 0) @(posedge clk);
	endtask

	// Random value biased toward small magnitudes and boundary patterns.
	function automatic logic [WIDTH-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return MOST_NEG;
			2: return MOST_POS;
			3: return -$urandom_range(1, 1000);
			4: return 0;
			default: return $urandom_range(1, 5000) * ($urandom_range(0, 1) ? 1 : -1);
		endcase
	endfunction

	task automatic test_extremes();
		logic [WIDTH-1:0] vals[6];
		vals = '{0, 1, -1, MOST_NEG, MOST_POS, 32'h5555_AAAA};
		foreach (vals[i])
			foreach (vals[j])
				if (i < 5 || j < 5) send_fraction(vals[i], vals[j]);
		send_fraction(MOST_NEG, -2);	// reduces to the positive value 2^(WIDTH-2), not saturated
		send_fraction(12, -18);
		send_fraction(-7, 0);
		drain_results();
	endtask

	task automatic test_common_factors(int count);
		logic [WIDTH-1:0] f, a, b;
		repeat (count) begin
			f = $urandom_range(1, 2000);
			a = $urandom_range(0, 3000) * f;
			b = $urandom_range(0, 3000) * f;
			if ($urandom_range(0, 1)) a = -a;
			if ($urandom_range(0, 1)) b = -b;
			send_paced(a, b);
		end
		drain_results();
	endtask

	task automatic test_random(int count);
		repeat (count) send_paced(pick_value(), pick_value());
		drain_results();
	endtask

	// Receiver holds off while the sender keeps offering, so the queue fills.
	task automatic test_backpressure();
		hold_off_req = 1'b1;
		repeat (8) send_fraction($urandom, $urandom);
		hold_off_req = 1'b0;
		drain_results();
	endtask

	// Receiver stall pattern; a long hold-off when requested.
	initial begin
		int phase;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				out_stall <= 1'b1;
				repeat (600) @(posedge clk);
				out_stall <= 1'b0;
				wait (!hold_off_req);
			end else begin
				phase = $urandom_range(0, 7);
				out_stall <= (phase < 3);
			end
		end
	end

	// Result checker: compare each accepted beat with the oldest expectation.
	always @(posedge clk) begin
		fraction_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (reduced_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h/%h", num_out, den_out);
			end else begin
				exp_r = reduced_q.pop_front();
				if (exp_r.num !== num_out || exp_r.den !== den_out || exp_r.err !== div_error) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %h/%h err %b, got %h/%h err %b",
							exp_r.num, exp_r.den, exp_r.err, num_out, den_out, div_error);
				end
			end
		end
	end

	// Watchdog: cycles with no beat accepted on either side.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	initial begin
		in_valid = 1'b0;
		num_in = '0;
		den_in = '0;
		arst_n = 1'b0;
		mismatches = 0;
		idle_cycles = 0;
		hold_off_req = 1'b0;
		burst_left = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_backpressure();
		test_common_factors(600);
		test_random(600);
		repeat (200) @(posedge clk);
		if (mismatches == 0 && reduced_q.size() == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

### files.f
src/ratn_pkg.sv
src/ratn_front.sv
src/ratn_back.sv
src/rational_normalizer_unit.sv
src/ratn_checker.sv
verif/tb.sv
